FILE: hdl/i2cms_pkg.sv
// Shared types, codes and constants of the I2C master transaction sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

    // Request and poll codes on the input tuser field
    localparam logic [3:0] OP_POLL        = 4'd0;
    localparam logic [3:0] OP_START       = 4'd1;
    localparam logic [3:0] OP_START_WAIT  = 4'd2;
    localparam logic [3:0] OP_STOP        = 4'd3;
    localparam logic [3:0] OP_READ_ACK    = 4'd4;
    localparam logic [3:0] OP_READ_NAK    = 4'd5;
    localparam logic [3:0] OP_READ_WORD   = 4'd6;
    localparam logic [3:0] OP_READ_ARRAY  = 4'd7;
    localparam logic [3:0] OP_READ_OMIT   = 4'd8;
    localparam logic [3:0] OP_WRITE       = 4'd9;
    localparam logic [3:0] OP_WRITE_2     = 4'd10;

    // Engine status codes (low three bits already masked)
    localparam logic [7:0] SC_START       = 8'h08;
    localparam logic [7:0] SC_REP_START   = 8'h10;
    localparam logic [7:0] SC_MT_SLA_ACK  = 8'h18;
    localparam logic [7:0] SC_MT_SLA_NACK = 8'h20;
    localparam logic [7:0] SC_MT_DATA_ACK = 8'h28;
    localparam logic [7:0] SC_MR_SLA_ACK  = 8'h40;
    localparam logic [7:0] SC_MR_SLA_NACK = 8'h48;
    localparam logic [7:0] STATUS_MASK    = 8'hF8;
    localparam logic [7:0] OMIT_NONE      = 8'hFF;

    // Queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Stream widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 72;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_START   = 8'b0000_0010,
        S_ADDR    = 8'b0000_0100,
        S_STOP    = 8'b0000_1000,
        S_WAITDEV = 8'b0001_0000,
        S_READ    = 8'b0010_0000,
        S_WRITE   = 8'b0100_0000,
        S_FAIL    = 8'b1000_0000
    } fsm_t;

    typedef enum logic [2:0] {
        PEND_NONE  = 3'd0,
        PEND_RACK  = 3'd1,
        PEND_RNAK  = 3'd2,
        PEND_WORD  = 3'd3,
        PEND_ARRAY = 3'd4,
        PEND_WR    = 3'd5,
        PEND_WR2   = 3'd6
    } pend_t;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_SEND  = 3'd2,
        CMD_RACK  = 3'd3,
        CMD_RNAK  = 3'd4,
        CMD_STOP  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_POLL    = 2'd0,
        KIND_CONNECT = 2'd1,
        KIND_STOP    = 2'd2,
        KIND_DATA    = 2'd3
    } kind_t;

    // Classified item as it travels through the queue
    typedef struct packed {
        kind_t       kind;
        logic        wait_mode;
        pend_t       pend;
        logic [7:0]  address;
        logic [7:0]  len;
        logic [7:0]  mask;
        logic [7:0]  omit_tgt;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic        done;
        logic        sbusy;
        logic [7:0]  status;
        logic [7:0]  rx;
    } item_t;

    // One result item
    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  cbyte;
        logic        busy;
        logic        ew;
        logic [7:0]  eidx;
        logic [15:0] evalue;
        logic [7:0]  byte_val;
        logic [15:0] word_val;
        logic [7:0]  err;
    } result_t;

endpackage

FILE: hdl/i2cms_front.sv
// Front end: decodes and classifies incoming items for the queue.
`timescale 1ns / 1ps

module i2cms_front
    import i2cms_pkg::*;
(
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output item_t                item
);

    logic [3:0] op;
    logic [7:0] len;
    logic [7:0] omit_pos;

    assign op       = s_tuser;
    assign len      = s_tdata[15:8];
    assign omit_pos = s_tdata[31:24];

    // Classify the operation code; unknown codes act as polls
    always_comb
    begin
        item.kind      = KIND_POLL;
        item.pend      = PEND_NONE;
        item.wait_mode = (op == OP_START_WAIT);
        case (op)
            OP_START, OP_START_WAIT: item.kind = KIND_CONNECT;
            OP_STOP:                 item.kind = KIND_STOP;
            OP_READ_ACK:
            begin
                item.kind = KIND_DATA;
                item.pend = PEND_RACK;
            end
            OP_READ_NAK:
            begin
                item.kind = KIND_DATA;
                item.pend = PEND_RNAK;
            end
            OP_READ_WORD:
            begin
                item.kind = KIND_DATA;
                item.pend = PEND_WORD;
            end
            OP_READ_ARRAY, OP_READ_OMIT:
            begin
                item.kind = KIND_DATA;
                item.pend = PEND_ARRAY;
            end
            OP_WRITE:
            begin
                item.kind = KIND_DATA;
                item.pend = PEND_WR;
            end
            OP_WRITE_2:
            begin
                item.kind = KIND_DATA;
                item.pend = PEND_WR2;
            end
            default:
            begin
                item.kind = KIND_POLL;
                item.pend = PEND_NONE;
            end
        endcase

        // Unpack fields, precompute the omitted slot and mask the status
        item.address  = s_tdata[7:0];
        item.len      = len;
        item.mask     = s_tdata[23:16];
        item.omit_tgt = (op == OP_READ_OMIT) ? 8'(len - omit_pos) : OMIT_NONE;
        item.d1       = s_tdata[39:32];
        item.d2       = s_tdata[47:40];
        item.done     = s_tdata[48];
        item.sbusy    = s_tdata[49];
        item.status   = s_tdata[57:50] & STATUS_MASK;
        item.rx       = s_tdata[65:58];
    end

endmodule

FILE: hdl/i2cms_queue.sv
// Short queue of classified items between front and back.
`timescale 1ns / 1ps

module i2cms_queue
    import i2cms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  not_full,
    input  logic  pop,
    output item_t head,
    output logic  not_empty
);

    item_t             slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign not_full  = (count_reg != QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hdl/i2cms_back.sv
// Back end: sequencer state, engine commands and the registered result item.
`timescale 1ns / 1ps

module i2cms_back
    import i2cms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    item_valid,
    output logic    item_pop,
    output result_t res,
    output logic    res_valid,
    input  logic    res_ready
);

    fsm_t        st_reg,         st_next;
    pend_t       pend_reg,       pend_next;
    logic [7:0]  addr_reg,       addr_next;
    logic [7:0]  err_reg,        err_next;
    logic [15:0] word_reg,       word_next;
    logic        connecting_reg, connecting_next;
    logic        connected_reg,  connected_next;
    logic        msb_reg,        msb_next;
    logic        failed_reg,     failed_next;
    logic        stopreq_reg,    stopreq_next;
    logic        waitm_reg,      waitm_next;
    logic [7:0]  mask_reg,       mask_next;
    logic [7:0]  slot_reg,       slot_next;
    logic [7:0]  omit_reg,       omit_next;
    logic [7:0]  held_reg,       held_next;
    result_t     res_reg,        res_next;
    logic        res_valid_reg;

    logic [7:0]  remain;

    assign item_pop  = item_valid && (!res_valid_reg || res_ready);
    assign res       = res_reg;
    assign res_valid = res_valid_reg;
    assign remain    = word_reg[7:0];

    // Next state and result for the item at the queue head
    always_comb
    begin
        st_next         = st_reg;
        pend_next       = pend_reg;
        addr_next       = addr_reg;
        err_next        = err_reg;
        word_next       = word_reg;
        connecting_next = connecting_reg;
        connected_next  = connected_reg;
        msb_next        = msb_reg;
        failed_next     = failed_reg;
        stopreq_next    = stopreq_reg;
        waitm_next      = waitm_reg;
        mask_next       = mask_reg;
        slot_next       = slot_reg;
        omit_next       = omit_reg;
        held_next       = held_reg;
        res_next        = '0;
        res_next.cmd    = CMD_NONE;

        case (item.kind)
            KIND_CONNECT:
            begin
                connecting_next = 1'b1;
                if (item.wait_mode)
                begin
                    waitm_next = 1'b1;
                end
                addr_next = item.address;
            end
            KIND_STOP:
            begin
                stopreq_next = 1'b1;
            end
            KIND_DATA:
            begin
                // Ignore data requests while another is pending
                if (pend_reg == PEND_NONE)
                begin
                    pend_next = item.pend;
                    case (item.pend)
                        PEND_WORD:
                        begin
                            word_next = '0;
                            msb_next  = 1'b1;
                        end
                        PEND_ARRAY:
                        begin
                            mask_next      = item.mask;
                            slot_next      = '0;
                            word_next[7:0] = item.len;
                            msb_next       = 1'b1;
                            omit_next      = item.omit_tgt;
                        end
                        PEND_WR:  word_next[7:0] = item.d1;
                        PEND_WR2: word_next      = {item.d1, item.d2};
                        default: ;
                    endcase
                end
            end
            default:
            begin
                // Poll: one step of the sequencer
                case (st_reg)
                    S_IDLE:
                    begin
                        if (connecting_reg)
                        begin
                            res_next.cmd = CMD_START;
                            st_next      = S_START;
                        end
                        else if (stopreq_reg && pend_reg == PEND_NONE && connected_reg)
                        begin
                            res_next.cmd = CMD_STOP;
                            st_next      = S_STOP;
                        end
                        else if (pend_reg inside {PEND_RACK, PEND_WORD, PEND_ARRAY})
                        begin
                            res_next.cmd = CMD_RACK;
                            st_next      = S_READ;
                        end
                        else if (pend_reg == PEND_RNAK)
                        begin
                            res_next.cmd = CMD_RNAK;
                            st_next      = S_READ;
                        end
                        else if (pend_reg inside {PEND_WR, PEND_WR2})
                        begin
                            res_next.cmd   = CMD_SEND;
                            res_next.cbyte = (pend_reg == PEND_WR) ? word_reg[7:0]
                                                                   : word_reg[15:8];
                            st_next        = S_WRITE;
                        end
                    end
                    S_START:
                    begin
                        if (item.done)
                        begin
                            if (item.status != SC_START && item.status != SC_REP_START)
                            begin
                                st_next  = S_FAIL;
                                err_next = item.status;
                            end
                            else
                            begin
                                res_next.cmd   = CMD_SEND;
                                res_next.cbyte = addr_reg;
                                st_next        = S_ADDR;
                            end
                        end
                    end
                    S_ADDR:
                    begin
                        if (item.done)
                        begin
                            if (!waitm_reg && item.status != SC_MT_SLA_ACK
                                && item.status != SC_MR_SLA_ACK)
                            begin
                                st_next  = S_FAIL;
                                err_next = item.status;
                            end
                            else if (waitm_reg && (item.status == SC_MT_SLA_NACK
                                     || item.status == SC_MR_SLA_NACK))
                            begin
                                // Device not there yet: stop and retry later
                                res_next.cmd = CMD_STOP;
                                st_next      = S_WAITDEV;
                            end
                            else
                            begin
                                connecting_next = 1'b0;
                                connected_next  = 1'b1;
                                waitm_next      = 1'b0;
                                st_next         = S_IDLE;
                            end
                        end
                    end
                    S_WAITDEV:
                    begin
                        if (!item.sbusy)
                        begin
                            st_next = S_IDLE;
                        end
                    end
                    S_STOP:
                    begin
                        if (!item.sbusy)
                        begin
                            connected_next = 1'b0;
                            stopreq_next   = 1'b0;
                            pend_next      = PEND_NONE;
                            st_next        = S_IDLE;
                        end
                    end
                    S_READ:
                    begin
                        if (item.done)
                        begin
                            case (pend_reg)
                                PEND_RACK, PEND_RNAK:
                                begin
                                    word_next[7:0] = item.rx;
                                    pend_next      = PEND_NONE;
                                    st_next        = S_IDLE;
                                end
                                PEND_WORD:
                                begin
                                    if (msb_reg)
                                    begin
                                        word_next    = {item.rx, 8'h00};
                                        msb_next     = 1'b0;
                                        res_next.cmd = CMD_RNAK;
                                    end
                                    else
                                    begin
                                        word_next = word_reg | {8'h00, item.rx};
                                        pend_next = PEND_NONE;
                                        st_next   = S_IDLE;
                                    end
                                end
                                PEND_ARRAY:
                                begin
                                    if (msb_reg)
                                    begin
                                        held_next    = item.rx & mask_reg;
                                        msb_next     = 1'b0;
                                        res_next.cmd = (remain < 8'd2) ? CMD_RNAK : CMD_RACK;
                                    end
                                    else
                                    begin
                                        res_next.ew     = 1'b1;
                                        res_next.eidx   = slot_reg;
                                        res_next.evalue = {held_reg, item.rx};
                                        if (remain < 8'd2)
                                        begin
                                            pend_next = PEND_NONE;
                                            st_next   = S_IDLE;
                                        end
                                        else
                                        begin
                                            // Omitted slot is overwritten by the next element
                                            if (!omit_reg[7] && remain == omit_reg)
                                            begin
                                                omit_next = OMIT_NONE;
                                            end
                                            else
                                            begin
                                                slot_next      = slot_reg + 8'd1;
                                                word_next[7:0] = remain - 8'd1;
                                            end
                                            msb_next     = 1'b1;
                                            res_next.cmd = CMD_RACK;
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    S_WRITE:
                    begin
                        if (item.done)
                        begin
                            if (item.status != SC_MT_DATA_ACK)
                            begin
                                st_next  = S_FAIL;
                                err_next = item.status;
                            end
                            else if (pend_reg == PEND_WR2)
                            begin
                                pend_next = PEND_WR;
                                st_next   = S_IDLE;
                            end
                            else
                            begin
                                pend_next = PEND_NONE;
                                st_next   = S_IDLE;
                            end
                        end
                    end
                    S_FAIL:
                    begin
                        // Latch the sticky failure and drop the operation
                        failed_next = 1'b1;
                        pend_next   = PEND_NONE;
                        st_next     = S_IDLE;
                    end
                    default: ;
                endcase
            end
        endcase

        // Status fields reflect the updated state
        res_next.busy     = (st_next != S_IDLE || waitm_next || pend_next != PEND_NONE
                             || stopreq_next) && !failed_next;
        res_next.byte_val = word_next[7:0];
        res_next.word_val = word_next;
        res_next.err      = failed_next ? err_next : 8'h00;
    end

    // State and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= S_IDLE;
            pend_reg       <= PEND_NONE;
            addr_reg       <= '0;
            err_reg        <= '0;
            word_reg       <= '0;
            connecting_reg <= 1'b0;
            connected_reg  <= 1'b0;
            msb_reg        <= 1'b0;
            failed_reg     <= 1'b0;
            stopreq_reg    <= 1'b0;
            waitm_reg      <= 1'b0;
            mask_reg       <= '0;
            slot_reg       <= '0;
            omit_reg       <= '0;
            held_reg       <= '0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            if (item_pop)
            begin
                st_next_apply: begin end
                st_reg         <= st_next;
                pend_reg       <= pend_next;
                addr_reg       <= addr_next;
                err_reg        <= err_next;
                word_reg       <= word_next;
                connecting_reg <= connecting_next;
                connected_reg  <= connected_next;
                msb_reg        <= msb_next;
                failed_reg     <= failed_next;
                stopreq_reg    <= stopreq_next;
                waitm_reg      <= waitm_next;
                mask_reg       <= mask_next;
                slot_reg       <= slot_next;
                omit_reg       <= omit_next;
                held_reg       <= held_next;
                res_reg        <= res_next;
                res_valid_reg  <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/i2c_master_transaction_sequencer_top.sv
// I2C master transaction sequencer: one result item for every input item.
// Result path: the input item is written into the queue, then the result register is loaded.
// Throughput: one item per cycle while the queue is not full; the 4-entry queue decouples input from a stalled output.
// Reset (rst_n, async, active low) clears the queue, the sequencer state and the result.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_top
    import i2cms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // target_address, length, read_mask, omit_position, data_first, data_second,
    // transfer_done, stop_busy, bus_status, bus_data, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // engine_command, command_byte, busy_res, element_write, element_index,
    // element_value, byte_value, word_value, error_status, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    item_t   front_item;
    item_t   head_item;
    logic    q_not_full;
    logic    q_not_empty;
    logic    q_pop;
    result_t res;

    i2cms_front u_front
    (
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .item    (front_item)
    );

    i2cms_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && q_not_full),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .head      (head_item),
        .not_empty (q_not_empty)
    );

    i2cms_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (head_item),
        .item_valid (q_not_empty),
        .item_pop   (q_pop),
        .res        (res),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready)
    );

    assign s_tready = q_not_full;

    // Pack result fields, lowest first
    assign m_tdata = {3'b000, res.err, res.word_val, res.byte_val, res.evalue, res.eidx,
                      res.ew, res.busy, res.cbyte, res.cmd};

endmodule
